@@ rtl/dvc_pkg.sv @@
// dvc_pkg: shared types and constants of the duplicate value counter
// no dependencies; imported by dvc_out_if, front, back and checker

package dvc_pkg;

  localparam int unsigned COUNT_BITS = 6;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // control flags that travel with each queued beat
  typedef struct packed {
    logic wr;    // element is stored
    logic last;  // element closes the data set
  } dvc_ctrl_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] r;
    r = (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
    return r;
  endfunction

endpackage

@@ rtl/dvc_if.sv @@
// dvc_in_if, dvc_out_if: valid/ready channels of the duplicate value counter
// depends on dvc_pkg for the count width

interface dvc_in_if #(
  parameter int unsigned VALUE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         last_item;

  modport source (output valid, value, last_item, input ready);
  modport sink   (input valid, value, last_item, output ready);
endinterface

interface dvc_out_if
  import dvc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value_res;
  logic [COUNT_BITS-1:0]        count;
  logic                         last_result;

  modport source (output valid, value_res, count, last_result, input ready);
  modport sink   (input valid, value_res, count, last_result, output ready);
endinterface

@@ rtl/dvc_ram.sv @@
// dvc_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module dvc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dvc_queue.sv @@
// dvc_queue: two-entry queue between the front and the back
// no dependencies

module dvc_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/dvc_front.sv @@
// dvc_front: accepts input beats, tracks the fill level and marks store or drop
// depends on dvc_pkg and dvc_in_if

module dvc_front
  import dvc_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 32,
  parameter int unsigned VALUE_BITS = 16,
  localparam int unsigned AW = $clog2(MAX_ITEMS),
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1),
  localparam int unsigned QW = $bits(dvc_ctrl_t) + CW + AW + VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dvc_in_if.sink        in_i,
  output logic          push_o,
  output logic [QW-1:0] push_data_o,
  input  logic          full_i
);

  logic [CW-1:0] fill_q, fill_d;
  logic          accept;
  logic          room;
  dvc_ctrl_t     ctrl;
  logic [CW-1:0] n_after;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign room       = (fill_q < CW'(MAX_ITEMS));
  assign n_after    = room ? fill_q + CW'(1) : fill_q;

  always_comb begin
    ctrl.wr   = room;
    ctrl.last = in_i.last_item;
  end

  assign push_o      = accept;
  assign push_data_o = {ctrl, n_after, fill_q[AW-1:0], in_i.value};

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = in_i.last_item ? '0 : n_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

@@ rtl/dvc_back.sv @@
// dvc_back: writes the store and runs the frequency scan, one pass per element
// depends on dvc_pkg, dvc_ram and dvc_out_if

module dvc_back
  import dvc_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 32,
  parameter int unsigned VALUE_BITS = 16,
  localparam int unsigned AW = $clog2(MAX_ITEMS),
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1),
  localparam int unsigned QW = $bits(dvc_ctrl_t) + CW + AW + VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          pop_o,
  input  logic [QW-1:0] pop_data_i,
  input  logic          empty_i,
  dvc_out_if.source     out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDI  = 3'd1;
  localparam logic [2:0] S_TGT  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  dvc_ctrl_t             q_ctrl;
  logic [CW-1:0]         q_n;
  logic [AW-1:0]         q_addr;
  logic [VALUE_BITS-1:0] q_value;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         n_q, n_d;
  logic [AW-1:0]         i_q, i_d;
  logic [AW-1:0]         j_q, j_d;
  logic [AW-1:0]         c_q, c_d;
  logic [VALUE_BITS-1:0] tgt_q, tgt_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  seen_q, seen_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [VALUE_BITS-1:0] pend_val_q, pend_val_d;
  logic [COUNT_BITS-1:0] pend_cnt_q, pend_cnt_d;
  logic                  out_vld_q, out_vld_d;
  logic [VALUE_BITS-1:0] out_val_q, out_val_d;
  logic [COUNT_BITS-1:0] out_cnt_q, out_cnt_d;
  logic                  out_last_q, out_last_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic                  out_free;
  logic                  eq;
  logic                  scan_end;
  logic                  last_i;

  assign {q_ctrl, q_n, q_addr, q_value} = pop_data_i;

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign ram_we   = pop_o && q_ctrl.wr;
  assign out_free = !out_vld_q || out_o.ready;
  assign eq       = (ram_rdata == tgt_q);
  assign scan_end = ((CW'(c_q) + CW'(1)) == n_q);
  assign last_i   = ((CW'(i_q) + CW'(1)) == n_q);

  always_comb begin
    case (state_q)
      S_RDI:   ram_raddr = i_q;
      S_TGT:   ram_raddr = '0;
      default: ram_raddr = j_q;
    endcase
  end

  dvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_addr),
    .wdata_i (q_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    i_d        = i_q;
    j_d        = j_q;
    c_d        = c_q;
    tgt_d      = tgt_q;
    cnt_d      = cnt_q;
    seen_d     = seen_q;
    pend_vld_d = pend_vld_q;
    pend_val_d = pend_val_q;
    pend_cnt_d = pend_cnt_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_val_d  = out_val_q;
    out_cnt_d  = out_cnt_q;
    out_last_d = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (pop_o && q_ctrl.last) begin
          n_d     = q_n;
          i_d     = '0;
          state_d = S_RDI;
        end
      end
      S_RDI: begin
        state_d = S_TGT;
      end
      S_TGT: begin
        tgt_d   = ram_rdata;
        c_d     = '0;
        j_d     = AW'(1);
        cnt_d   = '0;
        seen_d  = 1'b0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (eq) begin
          if (c_q < i_q) begin
            seen_d = 1'b1;
          end else begin
            cnt_d = sat_inc(cnt_q);
          end
        end
        c_d = c_q + AW'(1);
        j_d = j_q + AW'(1);
        if (scan_end) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (seen_q || !pend_vld_q || out_free) begin
          if (!seen_q) begin
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_val_d  = pend_val_q;
              out_cnt_d  = pend_cnt_q;
              out_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_val_d = tgt_q;
            pend_cnt_d = cnt_q;
          end
          if (last_i) begin
            state_d = S_FIN;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_RDI;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_val_d  = pend_val_q;
          out_cnt_d  = pend_cnt_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      n_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      c_q        <= '0;
      seen_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      i_q        <= i_d;
      j_q        <= j_d;
      c_q        <= c_d;
      seen_q     <= seen_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q      <= tgt_d;
    cnt_q      <= cnt_d;
    pend_val_q <= pend_val_d;
    pend_cnt_q <= pend_cnt_d;
    out_val_q  <= out_val_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.value_res   = out_val_q;
  assign out_o.count       = out_cnt_q;
  assign out_o.last_result = out_last_q;

endmodule

@@ rtl/duplicate_value_counter.sv @@
// duplicate_value_counter: top level, front, queue and back of the frequency count
// depends on dvc_pkg, dvc_if, dvc_front, dvc_queue, dvc_back
//
//   channel  dir  beat                          handshake
//   in_i     in   value, last_item              valid/ready
//   out_o    out  value_res, count, last_result valid/ready
//
// loading: one element per cycle while the queue has room, through a two-entry queue into the store
// counting: each stored element is read, then compared against the whole set (one store read port)
// reset: asynchronous, active low; store contents need no clearing
// stalls: the front keeps taking elements while the queue has room; the back
// holds in its decision step while the output register and pending result are full

module duplicate_value_counter
  import dvc_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 32,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dvc_in_if.sink    in_i,
  dvc_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned QW = $bits(dvc_ctrl_t) + CW + AW + VALUE_BITS;

  logic          push;
  logic [QW-1:0] push_data;
  logic          full;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          empty;

  dvc_front #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  dvc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  dvc_back #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .out_o      (out_o)
  );

endmodule

@@ rtl/dvc_checker.sv @@
// dvc_checker: port-level assertions for the duplicate value counter, bound to the top
// depends on dvc_pkg and the top level duplicate_value_counter

module dvc_checker
  import dvc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_last_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [VALUE_BITS-1:0] out_value_i,
  input logic [COUNT_BITS-1:0] out_count_i,
  input logic                  out_last_i
);

  // sets closed at the input whose final result has not left yet
  logic [3:0] open_q, open_d;
  logic       set_in, set_out;

  assign set_in  = in_valid_i && in_ready_i && in_last_i;
  assign set_out = out_valid_i && out_ready_i && out_last_i;

  always_comb begin
    open_d = open_q;
    if (set_in && !set_out) begin
      open_d = open_q + 4'd1;
    end else if (set_out && !set_in) begin
      open_d = open_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_value_i) && $stable(out_count_i) && $stable(out_last_i))
    else $error("stalled result beat changed");

  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i != '0)
    else $error("result with zero count");

  a_result_has_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != '0)
    else $error("result without a closed data set");

endmodule

bind duplicate_value_counter dvc_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_dvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_item),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value_res),
  .out_count_i (out_o.count),
  .out_last_i  (out_o.last_result)
);

@@ sim/dvc_count_checker.sv @@
`timescale 1ns / 1ps
// dvc_count_checker: watches both channels of the duplicate value counter, predicts
// the per-value tallies of each data set and compares every result beat
// depends on dvc_pkg for the count width

module dvc_count_checker
  import dvc_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 32,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic signed [VALUE_BITS-1:0] in_value_i,
  input  logic                         in_last_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [VALUE_BITS-1:0] out_value_i,
  input  logic [COUNT_BITS-1:0]        out_count_i,
  input  logic                         out_last_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0]        count;
    logic                         last;
  } tally_t;

  tally_t                       expected_tallies[$];
  logic signed [VALUE_BITS-1:0] set_values[MAX_ITEMS];
  int unsigned                  set_len;
  int                           fails = 0;
  int                           pending_n = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_n;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tally_t      want;
    bit          seen;
    int unsigned hits;
    int unsigned i;
    int unsigned j;
    if (!rst_ni) begin
      set_len = 0;
      expected_tallies.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        // elements beyond a full store are dropped
        if (set_len < MAX_ITEMS) begin
          set_values[set_len] = in_value_i;
          set_len++;
        end
        if (in_last_i) begin
          for (i = 0; i < set_len; i++) begin
            seen = 1'b0;
            for (j = 0; j < i; j++) begin
              if (set_values[j] == set_values[i]) seen = 1'b1;
            end
            if (!seen) begin
              hits = 0;
              for (j = i; j < set_len; j++) begin
                if (set_values[j] == set_values[i]) hits++;
              end
              want.value = set_values[i];
              want.count = (hits > COUNT_MAX) ? COUNT_MAX : COUNT_BITS'(hits);
              want.last  = 1'b0;
              expected_tallies.push_back(want);
            end
          end
          // a closed set always holds at least one element
          want = expected_tallies.pop_back();
          want.last = 1'b1;
          expected_tallies.push_back(want);
          set_len = 0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_tallies.size() == 0) begin
          $error("unexpected result beat: value_res %0d count %0d last_result %0b",
                 out_value_i, out_count_i, out_last_i);
          fails++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_value_i !== want.value) begin
            $error("value_res: expected %0d, got %0d", want.value, out_value_i);
            fails++;
          end
          if (out_count_i !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_count_i);
            fails++;
          end
          if (out_last_i !== want.last) begin
            $error("last_result: expected %0b, got %0b", want.last, out_last_i);
            fails++;
          end
        end
      end
    end
    pending_n = expected_tallies.size();
  end

endmodule

@@ sim/duplicate_value_counter_test.sv @@
`timescale 1ns / 1ps
// duplicate_value_counter_test: clock, reset and data-set stimulus for the counter
// depends on dvc_pkg, dvc_if, duplicate_value_counter and dvc_count_checker

module duplicate_value_counter_test;

  localparam int unsigned MAX_ITEMS    = 32;
  localparam int unsigned VALUE_BITS   = 16;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned in_beats = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;
  bit          hold_done = 1'b0;
  int          fail_count;
  int          pending_tallies;

  dvc_in_if  #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  dvc_out_if #(.VALUE_BITS(VALUE_BITS)) out_ch ();

  duplicate_value_counter #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  dvc_count_checker #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_value_i  (in_ch.value),
    .in_last_i   (in_ch.last_item),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_value_i (out_ch.value_res),
    .out_count_i (out_ch.count),
    .out_last_i  (out_ch.last_result),
    .fail_count_o(fail_count),
    .pending_o   (pending_tallies)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one element beat, then an optional idle gap
  task automatic send_element(input value_t v, input logic last);
    int unsigned r;
    int unsigned gap;
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.last_item <= last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    in_beats++;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r < 60)      gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else             gap = $urandom_range(20, 60);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // a data set drawn from a few repeated values, with some strays
  task automatic send_set(input int unsigned len, input int unsigned hues,
                          input int unsigned stray_pct);
    value_t      palette[8];
    value_t      v;
    int unsigned r;
    int unsigned k;
    for (k = 0; k < 8; k++) begin
      r = $urandom_range(0, 99);
      if (r < 5)       palette[k] = VALUE_MIN;
      else if (r < 10) palette[k] = VALUE_MAX;
      else             palette[k] = value_t'($urandom);
    end
    for (k = 0; k < len; k++) begin
      if (hues == 0 || $urandom_range(0, 99) < stray_pct) v = value_t'($urandom);
      else v = palette[$urandom_range(0, hues - 1)];
      send_element(v, k == len - 1);
    end
  endtask

  // receiver: random ready stretches, one long hold-off once the sender is busy
  initial begin
    int unsigned r;
    int unsigned len;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && in_beats >= 40) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        len = LONG_HOLD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ch.ready <= 1'b1;
          len = (r < 10) ? $urandom_range(20, 80) : $urandom_range(1, 20);
        end else begin
          out_ch.ready <= 1'b0;
          r = $urandom_range(0, 99);
          if (r < 80)      len = $urandom_range(1, 3);
          else if (r < 96) len = $urandom_range(4, 12);
          else             len = $urandom_range(20, 60);
        end
      end
      repeat (len - 1) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned target;
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    in_ch.last_item = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-element sets at the extremes
    send_element(VALUE_MIN, 1'b1);
    send_element(VALUE_MAX, 1'b1);
    // interleaved duplicates, order of first appearance
    send_element(value_t'(0), 1'b0);
    send_element(value_t'(-1), 1'b0);
    send_element(value_t'(0), 1'b0);
    send_element(value_t'(-1), 1'b0);
    send_element(value_t'(0), 1'b1);
    // all distinct
    send_element(value_t'(1), 1'b0);
    send_element(value_t'(2), 1'b0);
    send_element(value_t'(3), 1'b1);
    // one value repeated
    repeat (3) send_element(value_t'(5), 1'b0);
    send_element(value_t'(5), 1'b1);
    // bit patterns and both extremes together
    send_element(value_t'(16'h5555), 1'b0);
    send_element(value_t'(16'hAAAA), 1'b0);
    send_element(VALUE_MIN, 1'b0);
    send_element(VALUE_MAX, 1'b0);
    send_element(value_t'(16'hAAAA), 1'b0);
    send_element(VALUE_MIN, 1'b1);

    // full store: one value filling it, random values, then overflow with drops
    send_set(MAX_ITEMS, 1, 0);
    send_set(MAX_ITEMS, 0, 0);
    send_set(MAX_ITEMS + 4, 4, 10);

    target = in_beats + RANDOM_ITEMS;
    while (in_beats < target) begin
      r = $urandom_range(0, 99);
      if (r < 65)      len = $urandom_range(1, 6);
      else if (r < 88) len = $urandom_range(7, 16);
      else if (r < 97) len = $urandom_range(17, MAX_ITEMS);
      else             len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
      gaps_on = ($urandom_range(0, 3) != 0);
      send_set(len, $urandom_range(0, 6), $urandom_range(0, 30));
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending_tallies != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
